/* sv/gsgs_pkg.sv */
// Shared types and constants of the growable signed grid store.
`default_nettype none

package gsgs_pkg;

	// Width used for signed coordinate arithmetic (covers grids up to 64 wide).
	localparam int PHYS_W = 8;
	// Width of the value fields on the ports.
	localparam int PORT_VAL_W = 16;

	// Operation codes carried in the mode field; code 7 means nothing.
	localparam logic [2:0] MODE_SET    = 3'd0;
	localparam logic [2:0] MODE_GET    = 3'd1;
	localparam logic [2:0] MODE_FIND   = 3'd2;
	localparam logic [2:0] MODE_LEFT   = 3'd3;
	localparam logic [2:0] MODE_RIGHT  = 3'd4;
	localparam logic [2:0] MODE_TOP    = 3'd5;
	localparam logic [2:0] MODE_BOTTOM = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLAN,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [2:0]                    mode;
		logic signed [3:0]             row;
		logic signed [3:0]             col;
		logic signed [PORT_VAL_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic signed [PORT_VAL_W-1:0]  cell_value;
		logic signed [3:0]             hit_row;
		logic signed [3:0]             hit_col;
		logic                          found;
		logic                          last;
		logic [4:0]                    row_count;
		logic [4:0]                    col_count;
		logic signed [3:0]             row_base;
		logic signed [3:0]             col_base;
		logic                          maximizable;
	} out_item_t;

endpackage

`default_nettype wire

/* sv/gsgs_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface gsgs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/gsgs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gsgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

/* sv/growable_signed_grid_store.sv */
// Growable signed grid store: top level with row-wide memory and scan sequencer.
// Results: an out-of-window get, an empty window or the unused code is answered from the plan
//   state without a memory read; in-grid set, in-window get and the first edge element read the
//   row first; find reads one row after another until a hit or the last window row; further edge
//   elements one per cycle unless the result sink stalls. One transaction at a time, the next
//   accepted once the last result is registered. Reset clears window and row valid bits.
`default_nettype none

module growable_signed_grid_store
	import gsgs_pkg::*;
#(
	parameter int GRID_ROWS  = 16,
	parameter int GRID_COLS  = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	gsgs_stream_if.sink    req,
	gsgs_stream_if.source  rsp
);
	localparam int RAW   = $clog2(GRID_ROWS);
	localparam int CAW   = $clog2(GRID_COLS);
	localparam int ROW_W = GRID_COLS * VALUE_BITS;
	localparam logic signed [PHYS_W-1:0] ROW_OFS = PHYS_W'(GRID_ROWS / 2);
	localparam logic signed [PHYS_W-1:0] COL_OFS = PHYS_W'(GRID_COLS / 2);
	localparam logic [VALUE_BITS-1:0]    EMPTY   = {VALUE_BITS{1'b1}};

	// Map a logical row or column onto its memory row or cell index.
	function automatic logic [RAW-1:0] row_addr(input logic signed [4:0] r);
		logic signed [PHYS_W-1:0] p;
		p = PHYS_W'(r) + ROW_OFS;
		return p[RAW-1:0];
	endfunction

	function automatic logic [CAW-1:0] col_idx(input logic signed [4:0] c);
		logic signed [PHYS_W-1:0] p;
		p = PHYS_W'(c) + COL_OFS;
		return p[CAW-1:0];
	endfunction

	// Rows or columns in a window; zero when high is below low.
	function automatic logic [4:0] span(input logic signed [4:0] lo, input logic signed [4:0] hi);
		logic signed [5:0] d;
		d = 6'(hi) - 6'(lo) + 6'sd1;
		return (d < 6'sd0) ? 5'd0 : d[4:0];
	endfunction

	function automatic logic [PORT_VAL_W-1:0] to_port(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS+PORT_VAL_W-1:0] t;
		t = {{PORT_VAL_W{1'b0}}, v};
		return t[PORT_VAL_W-1:0];
	endfunction

	function automatic logic [VALUE_BITS-1:0] from_port(input logic [PORT_VAL_W-1:0] v);
		logic [VALUE_BITS+PORT_VAL_W-1:0] t;
		t = {{VALUE_BITS{1'b0}}, v};
		return t[VALUE_BITS-1:0];
	endfunction

	// ---------------------------------------------------------------------------------
	// State
	// ---------------------------------------------------------------------------------
	state_t state_q, state_d;

	// Transaction being served.
	logic [2:0]              mode_q;
	logic signed [3:0]       row_q, col_q;
	logic [VALUE_BITS-1:0]   val_q;

	// Live window bounds; low 0 / high -1 is the empty window.
	logic signed [4:0] rl_q, rh_q, cl_q, ch_q;

	// Scan position (logical) and the memory row whose data sits on the read port.
	logic signed [4:0] r_q, r_d, c_q, c_d;
	logic [RAW-1:0]    rd_row_q;

	// A row that was never written reads as all empty cells.
	logic [GRID_ROWS-1:0] row_vld_q;

	// Output register.
	out_item_t out_q, out_d;
	logic      out_vld_q;
	logic      out_free;

	// Memory port.
	logic             ram_we, ram_re;
	logic [RAW-1:0]   ram_raddr;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] eff_row, merged_row;

	// Result being emitted this cycle.
	logic                  em_vld;
	logic [VALUE_BITS-1:0] em_val;
	logic signed [4:0]     em_hr, em_hc;
	logic                  em_found, em_last;
	logic                  commit_set;

	logic signed [4:0] row_x, col_x;
	logic signed [4:0] nrl, nrh, ncl, nch;
	logic signed [4:0] b_rl, b_rh, b_cl, b_ch;
	logic signed [4:0] sel_col;
	logic [VALUE_BITS-1:0] sel_cell;
	logic [4:0]        rc, cc;
	logic              empty_win, in_win, set_in_grid;
	logic signed [PHYS_W-1:0] pr_in, pc_in;

	logic                     row_hit;
	logic signed [PHYS_W-1:0] hit_lc;

	gsgs_ram #(
		.WIDTH (ROW_W),
		.DEPTH (GRID_ROWS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rd_row_q),
		.wdata (merged_row),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------------------------
	// Datapath around the row read port
	// ---------------------------------------------------------------------------------
	assign row_x = 5'(row_q);
	assign col_x = 5'(col_q);

	assign pr_in = PHYS_W'(row_q) + ROW_OFS;
	assign pc_in = PHYS_W'(col_q) + COL_OFS;
	assign set_in_grid = (pr_in >= PHYS_W'(0)) && (pr_in < PHYS_W'(GRID_ROWS))
		&& (pc_in >= PHYS_W'(0)) && (pc_in < PHYS_W'(GRID_COLS));

	assign empty_win = (rh_q < rl_q) || (ch_q < cl_q);
	assign in_win    = (row_x >= rl_q) && (row_x <= rh_q) && (col_x >= cl_q) && (col_x <= ch_q);

	// Substitute empty cells for a row never written since reset.
	assign eff_row = row_vld_q[rd_row_q] ? ram_rdata : {GRID_COLS{EMPTY}};

	// Pick the column the current mode looks at.
	always_comb begin
		case (mode_q)
			MODE_GET:   sel_col = col_x;
			MODE_LEFT:  sel_col = cl_q;
			MODE_RIGHT: sel_col = ch_q;
			default:    sel_col = c_q;
		endcase
	end

	assign sel_cell = eff_row[int'(col_idx(sel_col)) * VALUE_BITS +: VALUE_BITS];

	always_comb begin
		merged_row = eff_row;
		merged_row[int'(col_idx(col_x)) * VALUE_BITS +: VALUE_BITS] = val_q;
	end

	// Leftmost in-window cell of the current row that equals the search value.
	always_comb begin
		logic signed [PHYS_W-1:0] lc;
		row_hit = 1'b0;
		hit_lc  = '0;
		for (int j = GRID_COLS - 1; j >= 0; j--) begin
			lc = PHYS_W'(j) - COL_OFS;
			if (lc >= PHYS_W'(cl_q) && lc <= PHYS_W'(ch_q)
				&& eff_row[j * VALUE_BITS +: VALUE_BITS] == val_q) begin
				row_hit = 1'b1;
				hit_lc  = lc;
			end
		end
	end

	// Window after a set widens it.
	assign nrl = (row_x < rl_q) ? row_x : rl_q;
	assign nrh = (row_x > rh_q) ? row_x : rh_q;
	assign ncl = (col_x < cl_q) ? col_x : cl_q;
	assign nch = (col_x > ch_q) ? col_x : ch_q;

	// ---------------------------------------------------------------------------------
	// Sequencer: plan the first read, then, with no sink stall, evaluate one row or cell per cycle
	// ---------------------------------------------------------------------------------
	assign out_free  = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		r_d        = r_q;
		c_d        = c_q;
		ram_re     = 1'b0;
		ram_raddr  = rd_row_q;
		ram_we     = 1'b0;
		commit_set = 1'b0;
		em_vld     = 1'b0;
		em_val     = EMPTY;
		em_hr      = '0;
		em_hc      = '0;
		em_found   = 1'b0;
		em_last    = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_PLAN;
				end
			end

			ST_PLAN: begin
				case (mode_q)
					MODE_SET: begin
						if (set_in_grid) begin
							ram_re    = 1'b1;
							ram_raddr = row_addr(row_x);
							state_d   = ST_EVAL;
						end else if (out_free) begin
							// Off-grid set: echo the value, leave the store alone.
							em_vld  = 1'b1;
							em_val  = val_q;
							state_d = ST_IDLE;
						end
					end
					MODE_GET: begin
						if (in_win) begin
							ram_re    = 1'b1;
							ram_raddr = row_addr(row_x);
							state_d   = ST_EVAL;
						end else if (out_free) begin
							em_vld  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					MODE_FIND, MODE_LEFT, MODE_RIGHT, MODE_TOP, MODE_BOTTOM: begin
						if (!empty_win) begin
							ram_re  = 1'b1;
							state_d = ST_EVAL;
							c_d     = cl_q;
							if (mode_q == MODE_FIND || mode_q == MODE_BOTTOM) begin
								r_d = rl_q;
							end else begin
								r_d = rh_q;
							end
							ram_raddr = row_addr(r_d);
						end else if (out_free) begin
							em_vld  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							em_vld  = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end

			ST_EVAL: begin
				case (mode_q)
					MODE_SET: begin
						if (out_free) begin
							ram_we     = 1'b1;
							commit_set = 1'b1;
							em_vld     = 1'b1;
							em_val     = val_q;
							state_d    = ST_IDLE;
						end
					end
					MODE_GET: begin
						if (out_free) begin
							em_vld  = 1'b1;
							em_val  = sel_cell;
							state_d = ST_IDLE;
						end
					end
					MODE_FIND: begin
						if (row_hit) begin
							if (out_free) begin
								em_vld   = 1'b1;
								em_val   = val_q;
								em_hr    = r_q;
								em_hc    = hit_lc[4:0];
								em_found = 1'b1;
								state_d  = ST_IDLE;
							end
						end else if (r_q == rh_q) begin
							if (out_free) begin
								em_vld  = 1'b1;
								state_d = ST_IDLE;
							end
						end else begin
							// Advance to the next row; its data arrives next cycle.
							r_d       = r_q + 5'sd1;
							ram_re    = 1'b1;
							ram_raddr = row_addr(r_d);
						end
					end
					MODE_LEFT, MODE_RIGHT: begin
						if (out_free) begin
							em_vld   = 1'b1;
							em_val   = sel_cell;
							em_hr    = r_q;
							em_hc    = sel_col;
							em_found = 1'b1;
							em_last  = (r_q == rl_q);
							if (r_q == rl_q) begin
								state_d = ST_IDLE;
							end else begin
								r_d       = r_q - 5'sd1;
								ram_re    = 1'b1;
								ram_raddr = row_addr(r_d);
							end
						end
					end
					MODE_TOP, MODE_BOTTOM: begin
						// Hold the row on the read port and walk its columns.
						if (out_free) begin
							em_vld   = 1'b1;
							em_val   = sel_cell;
							em_hr    = r_q;
							em_hc    = c_q;
							em_found = 1'b1;
							em_last  = (c_q == ch_q);
							if (c_q == ch_q) begin
								state_d = ST_IDLE;
							end else begin
								c_d = c_q + 5'sd1;
							end
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Counts and bases are reported after this transaction has acted.
	assign b_rl = commit_set ? nrl : rl_q;
	assign b_rh = commit_set ? nrh : rh_q;
	assign b_cl = commit_set ? ncl : cl_q;
	assign b_ch = commit_set ? nch : ch_q;
	assign rc   = span(b_rl, b_rh);
	assign cc   = span(b_cl, b_ch);

	always_comb begin
		out_d.cell_value  = to_port(em_val);
		out_d.hit_row     = em_hr[3:0];
		out_d.hit_col     = em_hc[3:0];
		out_d.found       = em_found;
		out_d.last        = em_last;
		out_d.row_count   = rc;
		out_d.col_count   = cc;
		out_d.row_base    = b_rl[3:0];
		out_d.col_base    = b_cl[3:0];
		out_d.maximizable = (rc > 5'd1) || (cc > 5'd1);
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	// ---------------------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
			row_vld_q <= '0;
			rl_q      <= 5'sd0;
			rh_q      <= -5'sd1;
			cl_q      <= 5'sd0;
			ch_q      <= -5'sd1;
		end else begin
			state_q <= state_d;
			if (em_vld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (commit_set) begin
				row_vld_q[rd_row_q] <= 1'b1;
				rl_q <= nrl;
				rh_q <= nrh;
				cl_q <= ncl;
				ch_q <= nch;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.payload.mode;
			row_q  <= req.payload.row;
			col_q  <= req.payload.col;
			val_q  <= from_port(req.payload.value);
		end
		if (ram_re) begin
			rd_row_q <= ram_raddr;
		end
		r_q <= r_d;
		c_q <= c_d;
		if (em_vld) begin
			out_q <= out_d;
		end
	end
endmodule

`default_nettype wire

/* tb/sv/tb_growable_signed_grid_store.sv */
// Self-checking testbench for the growable signed grid store: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_growable_signed_grid_store;
	import gsgs_pkg::*;

	// The mode field has one code with no operation behind it.
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam logic signed [15:0] EMPTY_VAL = -16'sd1;
	localparam int RANDOM_ITEMS = 245;
	// Receiver hold-off used to back the block up into its request port.
	localparam int HOLD_CYCLES = 150;
	// Longest find walks all sixteen rows; leave ample margin.
	localparam int DRAIN_CYCLES = 40;

	// One row of stimulus: the request, and an expectation typed in by hand
	// when it can be read off directly.
	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} grid_case_t;

	logic clk;
	logic arst_n;

	gsgs_stream_if #(.payload_t(in_item_t))  req_ch ();
	gsgs_stream_if #(.payload_t(out_item_t)) rsp_ch ();

	growable_signed_grid_store i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the grid and its live window.
	logic signed [15:0] grid_cells [0:15][0:15];
	logic signed [4:0]  row_lo, row_hi, col_lo, col_hi;

	out_item_t  grid_expect_q [$];   // results still owed by the block, oldest first
	grid_case_t offered_q [$];       // request on the bus, waiting for its transaction
	grid_case_t directed_rows [$];
	int         written_vals [$];    // values stored so far, so finds can hit

	int mismatches;
	int hold_request;
	int hold_left;
	bit no_idle;

	// Clock: 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Build one result from the current window.
	function automatic out_item_t grid_result(logic signed [15:0] v, int hr, int hc,
		bit hit, bit fin);
		out_item_t o;
		int rc;
		int cc;
		rc = int'(row_hi) - int'(row_lo) + 1;
		cc = int'(col_hi) - int'(col_lo) + 1;
		if (rc < 0)
			rc = 0;
		if (cc < 0)
			cc = 0;
		o.cell_value  = v;
		o.hit_row     = 4'(hr);
		o.hit_col     = 4'(hc);
		o.found       = hit;
		o.last        = fin;
		o.row_count   = 5'(rc);
		o.col_count   = 5'(cc);
		o.row_base    = 4'(row_lo);
		o.col_base    = 4'(col_lo);
		o.maximizable = (rc > 1) || (cc > 1);
		return o;
	endfunction

	// Advance the shadow grid by one request; queue its results when asked to.
	function automatic void grid_predict(in_item_t it, bit keep);
		out_item_t res [$];
		logic signed [15:0] v;
		bit empty;
		bit hit;
		int r;
		int c;
		empty = (row_hi < row_lo) || (col_hi < col_lo);
		case (it.mode)
			MODE_SET: begin
				if (it.row < row_lo)
					row_lo = it.row;
				if (it.row > row_hi)
					row_hi = it.row;
				if (it.col < col_lo)
					col_lo = it.col;
				if (it.col > col_hi)
					col_hi = it.col;
				grid_cells[it.row + 8][it.col + 8] = it.value;
				res.push_back(grid_result(it.value, 0, 0, 1'b0, 1'b1));
			end
			MODE_GET: begin
				v = EMPTY_VAL;
				// Inclusive bounds: row_hi itself is inside the window.
				if (it.row >= row_lo && it.row <= row_hi && it.col >= col_lo && it.col <= col_hi)
					v = grid_cells[it.row + 8][it.col + 8];
				res.push_back(grid_result(v, 0, 0, 1'b0, 1'b1));
			end
			MODE_FIND: begin
				hit = 1'b0;
				for (r = row_lo; r <= row_hi && !hit; r++)
					for (c = col_lo; c <= col_hi && !hit; c++)
						if (grid_cells[r + 8][c + 8] == it.value) begin
							res.push_back(grid_result(it.value, r, c, 1'b1, 1'b1));
							hit = 1'b1;
						end
				if (!hit)
					res.push_back(grid_result(EMPTY_VAL, 0, 0, 1'b0, 1'b1));
			end
			MODE_LEFT, MODE_RIGHT: begin
				if (empty) begin
					res.push_back(grid_result(EMPTY_VAL, 0, 0, 1'b0, 1'b1));
				end else begin
					c = (it.mode == MODE_LEFT) ? int'(col_lo) : int'(col_hi);
					for (r = row_hi; r >= row_lo; r--)
						res.push_back(grid_result(grid_cells[r + 8][c + 8], r, c, 1'b1,
							r == row_lo));
				end
			end
			MODE_TOP, MODE_BOTTOM: begin
				if (empty) begin
					res.push_back(grid_result(EMPTY_VAL, 0, 0, 1'b0, 1'b1));
				end else begin
					r = (it.mode == MODE_TOP) ? int'(row_hi) : int'(row_lo);
					for (c = col_lo; c <= col_hi; c++)
						res.push_back(grid_result(grid_cells[r + 8][c + 8], r, c, 1'b1,
							c == col_hi));
				end
			end
			default: begin
				res.push_back(grid_result(EMPTY_VAL, 0, 0, 1'b0, 1'b1));
			end
		endcase
		if (keep)
			foreach (res[i])
				grid_expect_q.push_back(res[i]);
	endfunction

	function automatic out_item_t outcome(int v, int hr, int hc, bit hit, bit fin,
		int rc, int cc, int rb, int cb, bit mx);
		out_item_t o;
		o.cell_value  = 16'(v);
		o.hit_row     = 4'(hr);
		o.hit_col     = 4'(hc);
		o.found       = hit;
		o.last        = fin;
		o.row_count   = 5'(rc);
		o.col_count   = 5'(cc);
		o.row_base    = 4'(rb);
		o.col_base    = 4'(cb);
		o.maximizable = mx;
		return o;
	endfunction

	function automatic void add_row(logic [2:0] m, int r, int c, int v, bit typed,
		out_item_t want);
		grid_case_t gc;
		gc.stim.mode  = m;
		gc.stim.row   = 4'(r);
		gc.stim.col   = 4'(c);
		gc.stim.value = 16'(v);
		gc.typed      = typed;
		gc.want       = want;
		directed_rows.push_back(gc);
	endfunction

	// Offer one request: idle a random number of cycles, then hold valid
	// until the transaction happens. Valid stays up after it; the next call
	// (or the end of the run) decides at the next falling edge.
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		grid_case_t gc;
		gc.stim  = it;
		gc.typed = typed;
		gc.want  = want;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 35) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		offered_q.push_back(gc);
		req_ch.payload = it;
		req_ch.valid   = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic compare_result(input out_item_t got, input out_item_t want);
		if (got.cell_value !== want.cell_value)
			report_mismatch($sformatf("cell_value got %0d want %0d",
				got.cell_value, want.cell_value));
		if (got.hit_row !== want.hit_row)
			report_mismatch($sformatf("hit_row got %0d want %0d", got.hit_row, want.hit_row));
		if (got.hit_col !== want.hit_col)
			report_mismatch($sformatf("hit_col got %0d want %0d", got.hit_col, want.hit_col));
		if (got.found !== want.found)
			report_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
		if (got.last !== want.last)
			report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
		if (got.row_count !== want.row_count)
			report_mismatch($sformatf("row_count got %0d want %0d",
				got.row_count, want.row_count));
		if (got.col_count !== want.col_count)
			report_mismatch($sformatf("col_count got %0d want %0d",
				got.col_count, want.col_count));
		if (got.row_base !== want.row_base)
			report_mismatch($sformatf("row_base got %0d want %0d", got.row_base, want.row_base));
		if (got.col_base !== want.col_base)
			report_mismatch($sformatf("col_base got %0d want %0d", got.col_base, want.col_base));
		if (got.maximizable !== want.maximizable)
			report_mismatch($sformatf("maximizable got %0b want %0b",
				got.maximizable, want.maximizable));
	endtask

	// Monitor: sample both channels at the rising edge. Predict on the request
	// transaction first, so a result in the same cycle always finds its entry.
	always @(posedge clk) begin
		grid_case_t gc;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (offered_q.size() == 0) begin
					report_mismatch("request transaction with nothing offered");
				end else begin
					gc = offered_q.pop_front();
					grid_predict(gc.stim, !gc.typed);
					if (gc.typed)
						grid_expect_q.push_back(gc.want);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (grid_expect_q.size() == 0)
					report_mismatch("result with no expectation waiting");
				else
					compare_result(rsp_ch.payload, grid_expect_q.pop_front());
			end
		end
	end

	// Result sink: random back-pressure, a long hold-off on request, and
	// full speed while the no-idle stretch runs.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_ch.ready = 1'b0;
			hold_left--;
		end else begin
			rsp_ch.ready = no_idle || ($urandom_range(99) >= 35);
		end
	end

	initial begin
		in_item_t  it;
		out_item_t blank;
		int span;
		int pick;
		int palette [6];

		palette = '{0, 1, 100, 16'h1234, 16'h4000, 16'h7FFF};
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready   = 1'b0;
		mismatches     = 0;
		hold_request   = 0;
		hold_left      = 0;
		no_idle        = 1'b0;

		// Shadow reset: every cell empty, window empty.
		foreach (grid_cells[r, c])
			grid_cells[r][c] = EMPTY_VAL;
		row_lo = 5'sd0;
		row_hi = -5'sd1;
		col_lo = 5'sd0;
		col_hi = -5'sd1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows. Empty window first: every mode must report nothing.
		blank = outcome(-1, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(MODE_GET,    0, 0, 0,     1, blank);
		add_row(MODE_FIND,   0, 0, -1,    1, blank);
		add_row(MODE_LEFT,   0, 0, 0,     1, blank);
		add_row(MODE_RIGHT,  0, 0, 0,     1, blank);
		add_row(MODE_TOP,    0, 0, 0,     1, blank);
		add_row(MODE_BOTTOM, 0, 0, 0,     1, blank);
		add_row(MODE_UNUSED, -8, 7, 32767, 1, blank);
		// First set opens a one-cell window at the origin.
		add_row(MODE_SET,  0, 0, 0, 1, outcome(0, 0, 0, 0, 1, 1, 1, 0, 0, 0));
		// Just past the high bounds: must read empty.
		add_row(MODE_GET,  1, 0, 0, 1, outcome(-1, 0, 0, 0, 1, 1, 1, 0, 0, 0));
		add_row(MODE_GET,  0, 1, 0, 1, outcome(-1, 0, 0, 0, 1, 1, 1, 0, 0, 0));
		add_row(MODE_LEFT, 0, 0, 0, 1, outcome(0, 0, 0, 1, 1, 1, 1, 0, 0, 0));
		add_row(MODE_FIND, 0, 0, 0, 1, outcome(0, 0, 0, 1, 1, 1, 1, 0, 0, 0));
		// Grow to a negative row base and the top of the value range.
		add_row(MODE_SET, -1, 1, 32767, 1, outcome(32767, 0, 0, 0, 1, 2, 2, -1, 0, 1));
		add_row(MODE_GET, -1, 1, 0,     1, outcome(32767, 0, 0, 0, 1, 2, 2, -1, 0, 1));
		// Corners of the coordinate range, outside the window.
		add_row(MODE_GET, -8, 7, 0, 1, outcome(-1, 0, 0, 0, 1, 2, 2, -1, 0, 1));
		add_row(MODE_GET, 7, -8, 0, 1, outcome(-1, 0, 0, 0, 1, 2, 2, -1, 0, 1));
		// From here the predictor supplies the expectations.
		add_row(MODE_SET,    1, -1, -1,    0, '0);
		add_row(MODE_FIND,   0, 0, -1,     0, '0);
		add_row(MODE_FIND,   0, 0, 32767,  0, '0);
		add_row(MODE_FIND,   0, 0, 12345,  0, '0);
		add_row(MODE_LEFT,   0, 0, 0,      0, '0);
		add_row(MODE_RIGHT,  0, 0, 0,      0, '0);
		add_row(MODE_TOP,    0, 0, 0,      0, '0);
		add_row(MODE_BOTTOM, 0, 0, 0,      0, '0);
		add_row(MODE_UNUSED, -1, -1, -1,   0, '0);

		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		written_vals = '{0, 32767, -1};

		// Random traffic. Sets stay near the origin at first and reach the
		// whole grid later, so the window grows step by step.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			span = 2 + n / 25;
			if (span > 8)
				span = 8;
			// Stop draining results for a while; the block must back up.
			if (n == 40)
				hold_request = HOLD_CYCLES;
			no_idle = (n >= 120) && (n < 180);

			it.row   = 4'($urandom_range(15));
			it.col   = 4'($urandom_range(15));
			it.value = 16'($urandom_range(32767));
			pick = $urandom_range(99);
			if (pick < 35) begin
				it.mode = MODE_SET;
				it.row  = 4'(int'($urandom_range(2 * span - 1)) - span);
				it.col  = 4'(int'($urandom_range(2 * span - 1)) - span);
				pick = $urandom_range(9);
				if (pick < 4)
					it.value = 16'(palette[$urandom_range(5)]);
				else if (pick == 9)
					it.value = EMPTY_VAL;
				written_vals.push_back(int'(it.value));
			end else if (pick < 55) begin
				it.mode = MODE_GET;
			end else if (pick < 75) begin
				it.mode = MODE_FIND;
				pick = $urandom_range(9);
				if (pick < 6)
					it.value = 16'(written_vals[$urandom_range(written_vals.size() - 1)]);
				else if (pick == 6)
					it.value = EMPTY_VAL;
			end else if (pick < 95) begin
				it.mode = MODE_LEFT + 3'($urandom_range(3));
			end else begin
				it.mode = MODE_UNUSED;
			end
			send_item(it, 1'b0, '0);
		end

		// Drop valid so the last request is not taken twice, then drain.
		@(negedge clk);
		req_ch.valid = 1'b0;
		no_idle = 1'b0;
		while (offered_q.size() != 0 || grid_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* growable_signed_grid_store.f */
sv/gsgs_pkg.sv
sv/gsgs_stream_if.sv
sv/gsgs_ram.sv
sv/growable_signed_grid_store.sv
tb/sv/tb_growable_signed_grid_store.sv
